@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lla_pkg.sv @@
package lla_pkg;

  localparam int REQ_W  = 2;
  localparam int COORD_W = 6;
  localparam int STEP_W = 16;
  localparam int GEN_W  = 32;
  localparam int MASK_W = 9;
  localparam int SIZE_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

  localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;
  localparam logic [SIZE_W-1:0] WIDTH_RST   = 7'd20;
  localparam logic [SIZE_W-1:0] HEIGHT_RST  = 7'd20;

  // three grid banks rotate between current, previous and next roles
  typedef logic [1:0] bank_t;
  localparam bank_t BANK_A = 2'd0;
  localparam bank_t BANK_B = 2'd1;
  localparam bank_t BANK_C = 2'd2;

  typedef struct packed {
    logic [MASK_W-1:0] birth;
    logic [MASK_W-1:0] survive;
  } rule_t;

  typedef enum logic [9:0] {
    S_CLR     = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_CELL_RD = 10'b00_0000_0100,
    S_CELL_WR = 10'b00_0000_1000,
    S_GRD     = 10'b00_0001_0000,
    S_GUSE    = 10'b00_0010_0000,
    S_CRD     = 10'b00_0100_0000,
    S_CUSE    = 10'b00_1000_0000,
    S_GEND    = 10'b01_0000_0000,
    S_RES     = 10'b10_0000_0000
  } state_t;

endpackage

@@ rtl/core/lla_ram.sv @@
module lla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lla_row_unit.sv @@
module lla_row_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0]             above,
  input  logic [MAX_WIDTH-1:0]             mid,
  input  logic [MAX_WIDTH-1:0]             below,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   act_w,
  input  lla_pkg::rule_t                   rule,
  output logic [MAX_WIDTH-1:0]             next_row
);

  localparam int CI = $clog2(MAX_WIDTH);

  logic [CI-1:0] last_col;
  logic          a_last, m_last, b_last;

  assign last_col = CI'(act_w - 1'b1);
  assign a_last   = above[last_col];
  assign m_last   = mid[last_col];
  assign b_last   = below[last_col];

  for (genvar x = 0; x < MAX_WIDTH; x++) begin : g_lane
    localparam int XL = (x + MAX_WIDTH - 1) % MAX_WIDTH;
    localparam int XR = (x + 1) % MAX_WIDTH;
    logic       al, ar, ml, mr, bl, br;
    logic       at_end;
    logic [3:0] cnt;
    logic       nb;

    // horizontal wrap at the active width
    assign at_end = (int'(act_w) == x + 1);
    assign al = (x == 0) ? a_last : above[XL];
    assign ml = (x == 0) ? m_last : mid[XL];
    assign bl = (x == 0) ? b_last : below[XL];
    assign ar = at_end ? above[0] : above[XR];
    assign mr = at_end ? mid[0]   : mid[XR];
    assign br = at_end ? below[0] : below[XR];

    assign cnt = {3'b0, al} + {3'b0, above[x]} + {3'b0, ar} + {3'b0, ml} +
                 {3'b0, mr} + {3'b0, bl} + {3'b0, below[x]} + {3'b0, br};
    assign nb  = mid[x] ? rule.survive[cnt] : rule.birth[cnt];

    assign next_row[x] = (int'(act_w) > x) ? nb : mid[x];
  end

endmodule

@@ rtl/core/life_like_automaton_torus.sv @@
// Life-like automaton on a torus: a grid of up to MAX_WIDTH x MAX_HEIGHT cells.
// Input channel (in_valid/in_ready) takes a request: write a cell, read a
// cell or advance in_step_count generations. Every request gives exactly one
// transfer on the result channel (out_valid/out_ready) with the addressed
// cell, the generation count and a range flag.
// cfg_we writes the birth and survival masks and the active size; the user
// must write them only while no request is in flight, as the block does not
// enforce it. A cell read or write passes a cell read and a cell write state,
// a bad coordinate or reserved request none, before the result state. An
// advance works on one row at a time with one row unit from the current bank;
// it stops early on a still life or a period-two oscillator.
// One request is in flight at a time; in_ready is high only when idle.
// After reset the block clears the grid, one row a cycle, before in_ready rises.
// A result that is not taken is held in the output register; the block then
// idles and takes the next request, holding its result until the first is
// transferred.
`include "assert_macros.svh"

module life_like_automaton_torus #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lla_pkg::REQ_W-1:0]        in_req_type,
  input  logic [lla_pkg::COORD_W-1:0]      in_col,
  input  logic [lla_pkg::COORD_W-1:0]      in_row,
  input  logic                             in_cell_value,
  input  logic [lla_pkg::STEP_W-1:0]       in_step_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_cell_alive,
  output logic [lla_pkg::GEN_W-1:0]        out_generation,
  output logic                             out_range_error,
  input  logic                             cfg_we,
  input  logic [lla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lla_pkg::MASK_W-1:0]       cfg_wdata
);

  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SWW = $clog2(MAX_WIDTH + 1);
  localparam int SHW = $clog2(MAX_HEIGHT + 1);
  localparam int KW  = $clog2(MAX_HEIGHT + 2);

  localparam logic [lla_pkg::STEP_W-1:0] STEP_ONE = lla_pkg::STEP_W'(1);

  lla_pkg::state_t state_r, state_nxt;

  logic [lla_pkg::MASK_W-1:0] birth_r, survive_r;
  logic [lla_pkg::SIZE_W-1:0] width_r, height_r;
  logic [SWW-1:0]             act_w;
  logic [SHW-1:0]             act_h;
  lla_pkg::rule_t             rule;

  lla_pkg::bank_t cur_sel_r, old_sel_r, new_sel_r;

  logic [lla_pkg::REQ_W-1:0]   req_r;
  logic [lla_pkg::COORD_W-1:0] col_r, row_r;
  logic                        val_r;
  logic [lla_pkg::STEP_W-1:0]  remain_r;
  logic                        have_older_r;
  logic                        eq_cur_r, eq_old_r;
  logic [KW-1:0]               k_r;
  logic [RW-1:0]               cpy_r;
  logic [RW-1:0]               clr_r;
  logic [MAX_WIDTH-1:0]        win_a_r, win_m_r;
  logic [lla_pkg::GEN_W-1:0]   gen_r;
  logic                        res_alive_r, res_err_r;

  logic                        out_valid_r, out_alive_r, out_err_r;
  logic [lla_pkg::GEN_W-1:0]   out_gen_r;

  logic                 cur_we, new_we;
  logic [RW-1:0]        cur_waddr, new_waddr, cur_raddr, old_raddr;
  logic [MAX_WIDTH-1:0] cur_wdata, new_wdata, cur_rdata, old_rdata;
  logic [MAX_WIDTH-1:0] bank_rdata [3];
  logic [MAX_WIDTH-1:0] row_new;
  logic [MAX_WIDTH-1:0] cell_bit;
  logic                 in_xfer, out_free, in_range;

  // size clamp: zero acts as one, above maximum acts as the maximum
  always_comb begin
    if (width_r == '0) begin
      act_w = SWW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      act_w = SWW'(MAX_WIDTH);
    end else begin
      act_w = SWW'(width_r);
    end
    if (height_r == '0) begin
      act_h = SHW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      act_h = SHW'(MAX_HEIGHT);
    end else begin
      act_h = SHW'(height_r);
    end
  end

  assign rule.birth   = birth_r;
  assign rule.survive = survive_r;

  assign in_ready  = (state_r == lla_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_range  = (int'(in_col) < int'(act_w)) && (int'(in_row) < int'(act_h));
  assign cell_bit  = MAX_WIDTH'(1) << col_r;

  // three grid banks
  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic          we;
    logic [RW-1:0] waddr, raddr;
    logic [MAX_WIDTH-1:0] wdata;

    assign we    = (cur_we && cur_sel_r == lla_pkg::bank_t'(b)) ||
                   (new_we && new_sel_r == lla_pkg::bank_t'(b));
    assign waddr = (cur_sel_r == lla_pkg::bank_t'(b)) ? cur_waddr : new_waddr;
    assign wdata = (cur_sel_r == lla_pkg::bank_t'(b)) ? cur_wdata : new_wdata;
    assign raddr = (old_sel_r == lla_pkg::bank_t'(b)) ? old_raddr : cur_raddr;

    lla_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (bank_rdata[b])
    );
  end

  assign cur_rdata = bank_rdata[cur_sel_r];
  assign old_rdata = bank_rdata[old_sel_r];

  lla_row_unit #(.MAX_WIDTH(MAX_WIDTH)) u_row (
    .above    (win_a_r),
    .mid      (win_m_r),
    .below    (cur_rdata),
    .act_w    (act_w),
    .rule     (rule),
    .next_row (row_new)
  );

  // memory port control
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = clr_r;
    cur_wdata = '0;
    new_we    = 1'b0;
    new_waddr = cpy_r;
    new_wdata = cur_rdata;
    cur_raddr = RW'(row_r);
    old_raddr = RW'(k_r - KW'(2));
    unique case (state_r)
      lla_pkg::S_CLR: begin
        cur_we = 1'b1;
      end
      lla_pkg::S_CELL_WR: begin
        cur_we    = (req_r == lla_pkg::REQ_WRITE);
        cur_waddr = RW'(row_r);
        cur_wdata = val_r ? (cur_rdata | cell_bit) : (cur_rdata & ~cell_bit);
      end
      lla_pkg::S_GRD: begin
        // wrapped row sequence: last, 0, 1, ..., h-1, 0
        if (k_r == '0) begin
          cur_raddr = RW'(act_h - 1'b1);
        end else if (int'(k_r) <= int'(act_h)) begin
          cur_raddr = RW'(k_r - 1'b1);
        end else begin
          cur_raddr = '0;
        end
      end
      lla_pkg::S_GUSE: begin
        new_we    = (k_r >= KW'(2));
        new_waddr = RW'(k_r - KW'(2));
        new_wdata = row_new;
      end
      lla_pkg::S_CRD: begin
        cur_raddr = cpy_r;
      end
      lla_pkg::S_CUSE: begin
        new_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lla_pkg::S_CLR: begin
        if (clr_r == RW'(MAX_HEIGHT - 1)) state_nxt = lla_pkg::S_IDLE;
      end
      lla_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_req_type == lla_pkg::REQ_ADVANCE) begin
            state_nxt = (in_step_count == '0) ? lla_pkg::S_RES : lla_pkg::S_GRD;
          end else if ((in_req_type == lla_pkg::REQ_WRITE ||
                        in_req_type == lla_pkg::REQ_READ) && in_range) begin
            state_nxt = lla_pkg::S_CELL_RD;
          end else begin
            state_nxt = lla_pkg::S_RES;
          end
        end
      end
      lla_pkg::S_CELL_RD: state_nxt = lla_pkg::S_CELL_WR;
      lla_pkg::S_CELL_WR: state_nxt = lla_pkg::S_RES;
      lla_pkg::S_GRD:     state_nxt = lla_pkg::S_GUSE;
      lla_pkg::S_GUSE: begin
        if (int'(k_r) == int'(act_h) + 1) begin
          state_nxt = (int'(act_h) == MAX_HEIGHT) ? lla_pkg::S_GEND : lla_pkg::S_CRD;
        end else begin
          state_nxt = lla_pkg::S_GRD;
        end
      end
      lla_pkg::S_CRD:  state_nxt = lla_pkg::S_CUSE;
      lla_pkg::S_CUSE: begin
        state_nxt = (cpy_r == RW'(MAX_HEIGHT - 1)) ? lla_pkg::S_GEND : lla_pkg::S_CRD;
      end
      lla_pkg::S_GEND: begin
        if (eq_cur_r || (have_older_r && eq_old_r) || remain_r == STEP_ONE) begin
          state_nxt = lla_pkg::S_RES;
        end else begin
          state_nxt = lla_pkg::S_GRD;
        end
      end
      lla_pkg::S_RES: begin
        if (out_free) state_nxt = lla_pkg::S_IDLE;
      end
      default: state_nxt = lla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lla_pkg::S_CLR;
      clr_r        <= '0;
      birth_r      <= lla_pkg::BIRTH_RST;
      survive_r    <= lla_pkg::SURVIVE_RST;
      width_r      <= lla_pkg::WIDTH_RST;
      height_r     <= lla_pkg::HEIGHT_RST;
      cur_sel_r    <= lla_pkg::BANK_A;
      new_sel_r    <= lla_pkg::BANK_B;
      old_sel_r    <= lla_pkg::BANK_C;
      gen_r        <= '0;
      have_older_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          lla_pkg::CFG_BIRTH:   birth_r   <= cfg_wdata;
          lla_pkg::CFG_SURVIVE: survive_r <= cfg_wdata;
          lla_pkg::CFG_WIDTH:   width_r   <= cfg_wdata[lla_pkg::SIZE_W-1:0];
          lla_pkg::CFG_HEIGHT:  height_r  <= cfg_wdata[lla_pkg::SIZE_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == lla_pkg::S_CLR) clr_r <= clr_r + 1'b1;

      if (in_xfer) have_older_r <= 1'b0;

      if (state_r == lla_pkg::S_GEND) begin
        if (eq_cur_r) begin
          // still life: the rest of the run changes nothing
          gen_r <= gen_r + lla_pkg::GEN_W'(remain_r);
        end else if (have_older_r && eq_old_r) begin
          // period two: land on the phase the full run would reach
          gen_r <= gen_r + lla_pkg::GEN_W'(remain_r);
          if (remain_r[0]) begin
            cur_sel_r <= new_sel_r;
            new_sel_r <= cur_sel_r;
          end
        end else begin
          gen_r        <= gen_r + 1'b1;
          old_sel_r    <= cur_sel_r;
          cur_sel_r    <= new_sel_r;
          new_sel_r    <= old_sel_r;
          have_older_r <= 1'b1;
        end
      end

      if (state_r == lla_pkg::S_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r       <= in_req_type;
      col_r       <= in_col;
      row_r       <= in_row;
      val_r       <= in_cell_value;
      remain_r    <= in_step_count;
      k_r         <= '0;
      eq_cur_r    <= 1'b1;
      eq_old_r    <= 1'b1;
      res_alive_r <= 1'b0;
      res_err_r   <= (in_req_type == lla_pkg::REQ_WRITE ||
                      in_req_type == lla_pkg::REQ_READ) && !in_range;
    end

    if (state_r == lla_pkg::S_CELL_WR) begin
      res_alive_r <= (req_r == lla_pkg::REQ_WRITE) ? val_r : |(cur_rdata & cell_bit);
    end

    if (state_r == lla_pkg::S_GUSE) begin
      win_a_r <= win_m_r;
      win_m_r <= cur_rdata;
      k_r     <= k_r + 1'b1;
      cpy_r   <= RW'(act_h);
      if (k_r >= KW'(2)) begin
        eq_cur_r <= eq_cur_r && (row_new == win_m_r);
        eq_old_r <= eq_old_r && (row_new == old_rdata);
      end
    end

    if (state_r == lla_pkg::S_CUSE) cpy_r <= cpy_r + 1'b1;

    if (state_r == lla_pkg::S_GEND) begin
      remain_r <= remain_r - 1'b1;
      k_r      <= '0;
      eq_cur_r <= 1'b1;
      eq_old_r <= 1'b1;
    end

    if (state_r == lla_pkg::S_RES && out_free) begin
      out_alive_r <= res_alive_r;
      out_err_r   <= res_err_r;
      out_gen_r   <= gen_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_alive  = out_alive_r;
  assign out_generation  = out_gen_r;
  assign out_range_error = out_err_r;

  `LLA_ASSERT(a_bank_distinct, (cur_sel_r != new_sel_r) && (cur_sel_r != old_sel_r) && (new_sel_r != old_sel_r), "grid banks overlap")
  `LLA_ASSERT(a_err_dead, (out_valid_r && out_err_r) |-> !out_alive_r, "range error with live cell")
  `LLA_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready, "request taken while busy")
  `LLA_ASSERT_NEXT(a_gen_hold_cell, (state_r == lla_pkg::S_CELL_WR), $stable(gen_r), "cell access moved generation")

endmodule
